@@ design/crlm_pkg.sv @@
package crlm_pkg;

  localparam int unsigned LOG2_CHUNK   = 10;
  localparam int unsigned NUM_CHANNELS = 2;

  localparam int unsigned SampleW = 32;
  localparam int unsigned SumW    = 63;
  localparam int unsigned ProdW   = 2 * SampleW;
  localparam int unsigned SlotW   = 3;
  localparam int unsigned FrameW  = 16;
  localparam int unsigned RootW   = 32;
  localparam int unsigned RemW    = RootW + 2;
  localparam int unsigned StepW   = $clog2(RootW);

  localparam logic [FrameW-1:0] LastFrame = FrameW'((1 << LOG2_CHUNK) - 1);
  localparam logic [StepW-1:0]  LastStep  = StepW'(RootW - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_ROOT,
    ST_LOAD
  } state_e;

  typedef struct packed {
    logic take;
    logic square;
    logic accum;
    logic root_step;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic last;
    logic root_done;
    logic out_free;
  } status_t;

endpackage

@@ design/crlm_ctrl.sv @@
module crlm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  crlm_pkg::status_t status_i,
  output crlm_pkg::cmd_t    cmd_o
);
  import crlm_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (status_i.first) begin
            state_d = ST_SQUARE;
          end
        end
      end
      ST_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd_o.accum = 1'b1;
        state_d     = status_i.last ? ST_ROOT : ST_LOAD;
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (status_i.root_done) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (status_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/crlm_datapath.sv @@
module crlm_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  crlm_pkg::cmd_t                 cmd_i,
  output crlm_pkg::status_t              status_o,
  input  logic signed [crlm_pkg::SampleW-1:0] sample_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [crlm_pkg::SampleW-1:0] channel0_sample_o,
  output logic [crlm_pkg::RootW-1:0]     rms_level_o,
  output logic                           chunk_done_o
);
  import crlm_pkg::*;

  logic [SlotW-1:0]   slot_q;
  logic [SlotW:0]     slot_inc;
  logic [FrameW-1:0]  frame_q;
  logic [SumW-1:0]    sum_q, sum_d;
  logic [SampleW-1:0] sample_q;
  logic [SampleW-1:0] mag_q, mag_d;
  logic [ProdW-1:0]   prod_q;
  logic [ProdW-1:0]   prod_sh;
  logic [ProdW-1:0]   rad_q;
  logic [RemW-1:0]    rem_q;
  logic [RemW+1:0]    rem_sh, trial;
  logic [RootW-1:0]   root_q;
  logic [StepW-1:0]   step_q;
  logic               done_q;
  logic               out_valid_q;
  logic [SampleW-1:0] ch0_q;
  logic [RootW-1:0]   rms_q;
  logic               chunk_done_q;

  assign slot_inc = {1'b0, slot_q} + 1'b1;
  assign mag_d    = sample_i[SampleW-1] ? (~sample_i + 1'b1) : sample_i;
  assign prod_sh  = prod_q >> LOG2_CHUNK;
  assign sum_d    = sum_q + prod_sh[SumW-1:0];
  assign rem_sh   = {rem_q, rad_q[ProdW-1 -: 2]};
  assign trial    = {2'b00, root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      frame_q <= '0;
      sum_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      if (cmd_i.take) begin
        slot_q <= (slot_inc >= (SlotW+1)'(NUM_CHANNELS)) ? '0 : slot_inc[SlotW-1:0];
      end
      if (cmd_i.accum) begin
        done_q <= (frame_q == LastFrame);
        if (frame_q == LastFrame) begin
          frame_q <= '0;
          sum_q   <= '0;
        end else begin
          frame_q <= frame_q + 1'b1;
          sum_q   <= sum_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      sample_q <= sample_i;
      mag_q    <= mag_d;
    end
    if (cmd_i.square) begin
      prod_q <= mag_q * mag_q;
    end
    if (cmd_i.accum) begin
      rad_q  <= {1'b0, sum_d};
      rem_q  <= '0;
      root_q <= '0;
      step_q <= LastStep;
    end else if (cmd_i.root_step) begin
      rad_q  <= rad_q << 2;
      step_q <= step_q - 1'b1;
      if (rem_sh >= trial) begin
        rem_q  <= RemW'(rem_sh - trial);
        root_q <= {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh[RemW-1:0];
        root_q <= {root_q[RootW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ch0_q        <= sample_q;
      rms_q        <= done_q ? root_q : '0;
      chunk_done_q <= done_q;
    end
  end

  assign status_o.first     = (slot_q == '0);
  assign status_o.last      = (frame_q == LastFrame);
  assign status_o.root_done = (step_q == '0);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o       = out_valid_q;
  assign channel0_sample_o = ch0_q;
  assign rms_level_o       = rms_q;
  assign chunk_done_o      = chunk_done_q;

endmodule

@@ design/chunk_rms_level_meter_top.sv @@
// A first-channel beat is registered, squared and accumulated, then loaded as a result beat;
// on the last frame of a chunk, 32 square-root iterations (one root bit each) come first.
// No new beat is taken until that load, which waits while an unaccepted result is held;
// other-channel beats are taken alone and give no result.
// Reset clears channel slot, frame count, accumulator and the output valid;
// the block is ready right after reset.
module chunk_rms_level_meter_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [crlm_pkg::SampleW-1:0] sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [crlm_pkg::SampleW-1:0] channel0_sample_o,
  output logic [crlm_pkg::RootW-1:0]          rms_level_o,
  output logic                                chunk_done_o
);
  import crlm_pkg::*;

  cmd_t    cmd;
  status_t status;

  crlm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  crlm_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .sample_i          (sample_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .channel0_sample_o (channel0_sample_o),
    .rms_level_o       (rms_level_o),
    .chunk_done_o      (chunk_done_o)
  );

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import crlm_pkg::*;

  localparam int unsigned ChunkFrames = 1 << LOG2_CHUNK;
  localparam int unsigned StallLimit  = 5000;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned HoldCycles  = 300;
  localparam logic signed [SampleW-1:0] MinSample = {1'b1, {(SampleW-1){1'b0}}};
  localparam logic signed [SampleW-1:0] MaxSample = {1'b0, {(SampleW-1){1'b1}}};

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic [RootW-1:0]          level;
    logic                      done;
  } frame_result_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic signed [SampleW-1:0] sample_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic signed [SampleW-1:0] channel0_sample_o;
  logic [RootW-1:0]          rms_level_o;
  logic                      chunk_done_o;

  frame_result_t    pending_frames[$];
  logic [SlotW-1:0] slot_q;
  logic [FrameW-1:0] frames_seen;
  logic [SumW-1:0]  energy_acc;

  int unsigned src_gap_pct;
  int unsigned sink_gap_pct;
  int unsigned hold_orders;
  int unsigned hold_served;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  int unsigned mismatches;
  int unsigned samples_sent;
  int unsigned frames_checked;
  int unsigned chunks_checked;

  chunk_rms_level_meter_top uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .sample_i          (sample_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .channel0_sample_o (channel0_sample_o),
    .rms_level_o       (rms_level_o),
    .chunk_done_o      (chunk_done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [RootW-1:0] floor_root(logic [63:0] value);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = RootW - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= value) root = trial;
    end
    return root[RootW-1:0];
  endfunction

  task automatic predict_level(logic signed [SampleW-1:0] value);
    logic [SampleW-1:0] mag;
    logic [63:0]        square;
    frame_result_t      res;
    logic [SlotW-1:0]   slot;
    slot = slot_q;
    if (int'(slot_q) + 1 >= NUM_CHANNELS) slot_q = '0;
    else slot_q = slot_q + 1'b1;
    if (slot != '0) return;
    mag = value[SampleW-1] ? (~value + 1'b1) : value;
    square = 64'(mag) * 64'(mag);
    energy_acc = energy_acc + SumW'(square >> LOG2_CHUNK);
    res.sample = value;
    res.done = (int'(frames_seen) >= ChunkFrames - 1);
    if (res.done) begin
      res.level = floor_root(64'(energy_acc));
      energy_acc = '0;
      frames_seen = '0;
    end else begin
      res.level = '0;
      frames_seen = frames_seen + 1'b1;
    end
    pending_frames.push_back(res);
  endtask

  function automatic logic signed [SampleW-1:0] rand_sample();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) return $urandom;
    if (pick < 65) begin
      case ($urandom_range(4))
        0: return MinSample;
        1: return MaxSample;
        2: return -1;
        3: return 0;
        default: return 1;
      endcase
    end
    if (pick < 85) return $signed(32'($urandom_range(2046))) - 1023;
    if (pick < 93) return MinSample + $signed(32'($urandom_range(255)));
    return MaxSample - $signed(32'($urandom_range(255)));
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch on %s: got %h, want %h", $time, field, got, want);
    mismatches++;
  endtask

  task automatic send_sample(logic signed [SampleW-1:0] value);
    while (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= value;
    do @(posedge clk_i); while (!in_ready_o);
    predict_level(value);
    samples_sent++;
  endtask

  task automatic set_idling(int unsigned src_pct, int unsigned sink_pct);
    src_gap_pct  = src_pct;
    sink_gap_pct = sink_pct;
  endtask

  task automatic test_extremes();
    logic signed [SampleW-1:0] picks [24];
    picks = '{32'sh0000_0000, MaxSample, 32'sh0000_0001, MinSample,
              -32'sd1, -32'sd1, MaxSample, 32'sh0000_0000,
              MinSample, 32'sh1234_5678, MinSample + 1, MaxSample,
              32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'sh5555_5555,
              32'sh0000_0400, MinSample, 32'sd31, 32'sh7FFF_0000,
              32'sd32, -32'sd31, -32'sd32, 32'sh0F0F_0F0F};
    set_idling(15, 45);
    foreach (picks[i]) send_sample(picks[i]);
  endtask

  task automatic test_random_mix();
    set_idling(15, 45);
    repeat (300) send_sample(rand_sample());
    set_idling(45, 15);
    repeat (300) send_sample(rand_sample());
    set_idling(0, 0);
    repeat (300) send_sample(rand_sample());
  endtask

  task automatic test_backpressure();
    set_idling(0, 0);
    hold_orders++;
    repeat (60) send_sample(rand_sample());
  endtask

  task automatic test_chunk_close();
    set_idling(15, 45);
    do send_sample(rand_sample()); while (!(slot_q == '0 && frames_seen == '0));
  endtask

  task automatic test_full_scale_chunk();
    set_idling(45, 15);
    repeat (ChunkFrames) begin
      send_sample(MinSample);
      repeat (NUM_CHANNELS - 1) send_sample(rand_sample());
    end
  endtask

  task automatic test_truncated_chunk();
    set_idling(0, 0);
    repeat (ChunkFrames) begin
      send_sample($signed(32'($urandom_range(62))) - 31);
      repeat (NUM_CHANNELS - 1) send_sample(rand_sample());
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (hold_served != hold_orders) begin
      hold_left   = HoldCycles;
      hold_served = hold_orders;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= sink_gap_pct);
    end
  end

  always @(posedge clk_i) begin
    frame_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_frames.size() == 0) begin
        report_mismatch("beat with no pending frame", channel0_sample_o, '0);
      end else begin
        want = pending_frames.pop_front();
        if (channel0_sample_o !== want.sample)
          report_mismatch("channel0_sample", channel0_sample_o, want.sample);
        if (rms_level_o !== want.level)
          report_mismatch("rms_level", rms_level_o, want.level);
        if (chunk_done_o !== want.done)
          report_mismatch("chunk_done", 32'(chunk_done_o), 32'(want.done));
        frames_checked++;
        if (want.done) chunks_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    sample_i     = '0;
    out_ready_i  = 1'b0;
    slot_q       = '0;
    frames_seen  = '0;
    energy_acc   = '0;
    src_gap_pct  = 0;
    sink_gap_pct = 0;
    hold_orders  = 0;
    hold_served  = 0;
    hold_left    = 0;
    quiet_cycles = 0;
    mismatches   = 0;
    samples_sent = 0;
    frames_checked = 0;
    chunks_checked = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_random_mix();
    test_backpressure();
    test_chunk_close();
    test_full_scale_chunk();
    test_truncated_chunk();

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    $display("Sent %0d samples; checked %0d frame beats and %0d chunk levels.",
             samples_sent, frames_checked, chunks_checked);
    $display("Covered field extremes, random mixes under stalls, a long output hold, "
             , "full-scale and truncated chunks; %0d mismatches.", mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
